// ===== rtl/shtlp_pkg.sv =====
// Shared types and constants for the symbol hash table.
package shtlp_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  // Number of table slots. It must be a power of two, since the home slot
  // is taken from the low bits of the hash.
  localparam int          TABLE_SIZE = 64;

  localparam int          NAME_W   = 64;
  localparam int          PAYLD_W  = 50;
  localparam logic [31:0] HASH_INIT = 32'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture request, start hashing
    logic hash_step;  // fold one character
    logic set_home;   // probe index <- hash mod size
    logic advance;    // probe index + 1
    logic clear;      // mark probe index as empty
    logic wr_used;    // write entry at probe index
    logic wr_tomb;    // mark probe index as tombstone
    logic res_hit;    // build result from current slot
    logic res_miss;   // build not-found/full result
  } shtlp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       hash_done;
    logic [1:0] mode;
    logic [1:0] st;       // status of probed slot
    logic       match;    // name and level equal
  } shtlp_sts_t;

endpackage

// ===== rtl/shtlp_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface shtlp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] name;
  logic [3:0]  level;
  logic [1:0]  kind;
  logic signed [31:0] value;
  logic [11:0] address;
  modport source (output valid, mode, name, level, kind, value, address, input ready);
  modport sink   (input valid, mode, name, level, kind, value, address, output ready);
endinterface

interface shtlp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  slot;
  logic [1:0]  found_kind;
  logic signed [31:0] found_value;
  logic [3:0]  found_level;
  logic [11:0] found_address;
  modport source (output valid, status, slot, found_kind, found_value, found_level,
                  found_address, input ready);
  modport sink   (input valid, status, slot, found_kind, found_value, found_level,
                  found_address, output ready);
endinterface

// ===== rtl/shtlp_ram.sv =====
// Generic single-port RAM with registered read.
module shtlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/shtlp_datapath.sv =====
// Hash unit, probe index, slot stores and result register.
module shtlp_datapath #(
  parameter int NAME_CHARS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  shtlp_pkg::shtlp_cmd_t cmd,
  output shtlp_pkg::shtlp_sts_t sts,
  input  logic [1:0]          in_mode,
  input  logic [63:0]         in_name,
  input  logic [3:0]          in_level,
  input  logic [1:0]          in_kind,
  input  logic [31:0]         in_value,
  input  logic [11:0]         in_address,
  output logic [1:0]          res_status,
  output logic [5:0]          res_slot,
  output logic [1:0]          res_kind,
  output logic [31:0]         res_value,
  output logic [3:0]          res_level,
  output logic [11:0]         res_address
);
  localparam int TABLE_SIZE = shtlp_pkg::TABLE_SIZE;
  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CW = $clog2(NAME_CHARS + 1);
  localparam int NB = 8 * NAME_CHARS;

  logic [1:0]  mode;
  logic [NB-1:0] name;
  logic [NB-1:0] shreg;
  logic [3:0]  level;
  logic [1:0]  kind;
  logic [31:0] value;
  logic [11:0] address;
  logic [31:0] hash;
  logic [CW-1:0] chars;
  logic        ended;
  logic [IW-1:0] idx;
  logic [1:0]  st_q;
  logic        st_we;
  logic [1:0]  st_wdata;
  logic [NB-1:0] name_rd;
  logic [shtlp_pkg::PAYLD_W-1:0] pay_rd;
  logic [7:0]  ch;
  logic [NB-1:0] canon;

  // Canonical name: zero everything from the first zero character on.
  always_comb begin
    logic z;
    z = 1'b0;
    canon = '0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (in_name[NB-1-8*i -: 8] == 8'd0) z = 1'b1;
      if (!z) canon[NB-1-8*i -: 8] = in_name[NB-1-8*i -: 8];
    end
  end

  assign ch = shreg[NB-1 -: 8];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode    <= in_mode;
      name    <= canon;
      shreg   <= canon;
      level   <= in_level;
      kind    <= in_kind;
      value   <= in_value;
      address <= in_address;
      hash    <= shtlp_pkg::HASH_INIT;
    end else if (cmd.hash_step) begin
      if (ch != 8'd0) hash <= (hash << 5) - hash + {24'd0, ch};
      shreg <= shreg << 8;
    end
    if (rst)              idx <= '0;
    else if (cmd.set_home) idx <= hash[IW-1:0];
    else if (cmd.advance) idx <= (idx == IW'(TABLE_SIZE - 1)) ? '0 : idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      chars <= '0;
      ended <= 1'b0;
    end else if (cmd.hash_step) begin
      chars <= chars + 1'b1;
      if (ch == 8'd0) ended <= 1'b1;
    end
  end

  // Slot status is emptied one slot per cycle by the clearing pass after reset.
  assign st_we    = cmd.clear || cmd.wr_used || cmd.wr_tomb;
  assign st_wdata = cmd.wr_used ? shtlp_pkg::SLOT_USED :
                    cmd.wr_tomb ? shtlp_pkg::SLOT_TOMB : shtlp_pkg::SLOT_EMPTY;

  shtlp_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_status (
    .clk(clk), .we(st_we), .addr(idx), .wdata(st_wdata), .rdata(st_q));

  shtlp_ram #(.WIDTH(NB), .DEPTH(TABLE_SIZE)) u_name (
    .clk(clk), .we(cmd.wr_used), .addr(idx), .wdata(name), .rdata(name_rd));

  shtlp_ram #(.WIDTH(shtlp_pkg::PAYLD_W), .DEPTH(TABLE_SIZE)) u_pay (
    .clk(clk), .we(cmd.wr_used), .addr(idx),
    .wdata({kind, value, level, address}), .rdata(pay_rd));

  assign sts.hash_done = ended || (chars == CW'(NAME_CHARS));
  assign sts.mode      = mode;
  assign sts.st        = st_q;
  assign sts.match     = (name_rd == name) && (pay_rd[15:12] == level);

  always_ff @(posedge clk) begin
    if (cmd.res_hit) begin
      res_status <= shtlp_pkg::STAT_OK;
      res_slot   <= 6'(idx);
      if (mode == shtlp_pkg::MODE_INSERT) begin
        {res_kind, res_value, res_level, res_address} <= '0;
      end else begin
        {res_kind, res_value, res_level, res_address} <= pay_rd;
      end
    end else if (cmd.res_miss) begin
      res_status <= (mode == shtlp_pkg::MODE_INSERT) ? shtlp_pkg::STAT_FULL
                                                     : shtlp_pkg::STAT_NOTFOUND;
      res_slot   <= '0;
      {res_kind, res_value, res_level, res_address} <= '0;
    end
  end
endmodule

// ===== rtl/shtlp_ctrl.sv =====
// Controller state machine sequencing hash and probe steps.
module shtlp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  output logic                  res_valid,
  input  logic                  res_ready,
  output shtlp_pkg::shtlp_cmd_t cmd,
  input  shtlp_pkg::shtlp_sts_t sts
);
  localparam int TABLE_SIZE = shtlp_pkg::TABLE_SIZE;
  localparam int PW = $clog2(TABLE_SIZE + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_WAIT, S_CHECK, S_DONE
  } state_t;
  state_t state;
  logic [PW-1:0] probes;
  logic accept;
  logic res_free;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  // The result register can take a new result once the old one is gone.
  assign res_free  = !res_valid || res_ready;

  always_comb begin
    cmd = '0;
    cmd.load = accept;
    case (state)
      S_CLEAR: begin
        cmd.clear   = 1'b1;
        cmd.advance = 1'b1;
      end
      S_HASH:  begin
        cmd.hash_step = !sts.hash_done;
        cmd.set_home  = sts.hash_done;
      end
      S_CHECK: begin
        if (res_free) begin
          if (sts.mode == shtlp_pkg::MODE_INSERT) begin
            if (sts.st != shtlp_pkg::SLOT_USED) begin
              cmd.wr_used = 1'b1;
              cmd.res_hit = 1'b1;
            end else if (probes == PW'(TABLE_SIZE - 1)) begin
              cmd.res_miss = 1'b1;
            end else begin
              cmd.advance = 1'b1;
            end
          end else if (sts.mode == shtlp_pkg::MODE_LOOKUP ||
                       sts.mode == shtlp_pkg::MODE_REMOVE) begin
            if (sts.st == shtlp_pkg::SLOT_USED && sts.match) begin
              cmd.res_hit = 1'b1;
              cmd.wr_tomb = (sts.mode == shtlp_pkg::MODE_REMOVE);
            end else if (sts.st == shtlp_pkg::SLOT_EMPTY ||
                         probes == PW'(TABLE_SIZE - 1)) begin
              cmd.res_miss = 1'b1;
            end else begin
              cmd.advance = 1'b1;
            end
          end else begin
            cmd.res_miss = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      probes    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.res_hit || cmd.res_miss) res_valid <= 1'b1;
      else if (res_ready)              res_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (probes == PW'(TABLE_SIZE - 1)) begin
            probes <= '0;
            state  <= S_IDLE;
          end else begin
            probes <= probes + 1'b1;
          end
        end
        S_IDLE:  if (accept) state <= S_HASH;
        S_HASH:  if (sts.hash_done) begin
          probes <= '0;
          state  <= S_READ;
        end
        S_READ:  state <= S_WAIT;
        S_WAIT:  state <= S_CHECK;
        S_CHECK: begin
          if (cmd.advance) begin
            probes <= probes + 1'b1;
            state  <= S_READ;
          end else if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_hit || cmd.res_miss) |=> res_valid) else $error("result not raised");
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(cmd.res_hit && cmd.res_miss)) else $error("hit and miss together");
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    probes < PW'(TABLE_SIZE)) else $error("probe count overrun");
  a_write_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_used || cmd.wr_tomb) |-> cmd.res_hit) else $error("write without result");
endmodule

// ===== rtl/symbol_hash_table_linear_probe_core.sv =====
// Top level of the symbol hash table with linear probing.
// One request (insert, lookup or remove of a name and scope level) is taken at
// a time and gives exactly one result. After reset the block writes every slot
// status to empty and takes no request during that pass. A request is then
// taken and folds the name into the hash one character per cycle, stopping at
// the terminating zero or after NAME_CHARS characters, before the home slot is
// set. At most TABLE_SIZE slots are probed; each passes through the read, wait
// and check states, since its status, name and payload come from memories with
// registered read. The result is valid the cycle after the check that decides
// it, and the next request can be taken in that same cycle; a result that is
// still waiting holds the block only when the next request reaches a slot check.
module symbol_hash_table_linear_probe_core #(
  parameter int NAME_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  shtlp_req_if.sink   req,
  shtlp_res_if.source res
);
  shtlp_pkg::shtlp_cmd_t cmd;
  shtlp_pkg::shtlp_sts_t sts;
  logic [31:0] fv;

  shtlp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready),
    .res_valid(res.valid), .res_ready(res.ready),
    .cmd(cmd), .sts(sts));

  shtlp_datapath #(.NAME_CHARS(NAME_CHARS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_mode(req.mode), .in_name(req.name), .in_level(req.level),
    .in_kind(req.kind), .in_value(req.value), .in_address(req.address),
    .res_status(res.status), .res_slot(res.slot), .res_kind(res.found_kind),
    .res_value(fv), .res_level(res.found_level), .res_address(res.found_address));

  assign res.found_value = fv;

  // The result must hold steady while it waits to be taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> $stable(res.status) && $stable(res.slot))
    else $error("result changed while stalled");
  // Once a request is taken the block is busy with it.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("request taken while busy");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != shtlp_pkg::STAT_OK) |-> res.slot == 6'd0)
    else $error("miss result has nonzero slot");
endmodule
